// ----- rtl/core/msd_pkg.sv -----
// ----------------------------------------------------------------------------
// msd_pkg
// Shared widths, codes, reset values and control bundles of the median ratio
// stall detector.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int STEP_W = 48;
  localparam int MED_W  = 47;
  localparam int THR_W  = 16;
  localparam int CONF_W = 4;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int LO_W   = 24;

  localparam int RING_DEPTH_DEF  = 20;
  localparam int MIN_SAMPLES_DEF = 5;

  localparam logic [THR_W-1:0]  THR_RESET  = 16'd1311;
  localparam logic [CONF_W-1:0] CONF_RESET = 4'd3;

  localparam logic OP_NOTE  = 1'b0;
  localparam logic OP_JUDGE = 1'b1;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_CONFIRM   = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_NONE        = 2'd0,
    VERDICT_CONFIRMED   = 2'd1,
    VERDICT_LATCHED     = 2'd2,
    VERDICT_PROVISIONAL = 2'd3
  } verdict_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic rank;
    logic select;
  } msd_ctl_t;

  typedef struct packed {
    logic lo;
    logic hi;
  } msd_mul_t;

endpackage

// ----- rtl/core/msd_cell.sv -----
// ----------------------------------------------------------------------------
// msd_cell
// One stage of the step chain: holds one stored step, ranks it against the
// circulating steps and passes the selected median along the chain.
// ----------------------------------------------------------------------------
module msd_cell
  import msd_pkg::*;
#(
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  msd_ctl_t         ctl,
  input  logic             valid,
  input  logic [CNT_W-1:0] k,
  input  logic [MED_W-1:0] own_in,
  output logic [MED_W-1:0] own_out,
  input  logic [MED_W-1:0] circ_in,
  input  logic             tok_in,
  output logic [MED_W-1:0] circ_out,
  output logic             tok_out
);

  logic [MED_W-1:0] own_r, own_nxt;
  logic [MED_W-1:0] circ_r, circ_nxt;
  logic             tok_r, tok_nxt;
  logic [CNT_W-1:0] less_r, less_nxt;
  logic [CNT_W-1:0] leq_r, leq_nxt;
  logic             hit;

  assign hit = valid && (less_r <= k) && (k < leq_r);

  always_comb begin
    own_nxt  = ctl.shift ? own_in : own_r;
    circ_nxt = circ_r;
    tok_nxt  = tok_r;
    less_nxt = less_r;
    leq_nxt  = leq_r;
    if (ctl.load) begin
      circ_nxt = own_r;
      tok_nxt  = valid;
      less_nxt = '0;
      leq_nxt  = '0;
    end else if (ctl.rank) begin
      if (tok_r && (circ_r < own_r)) begin
        less_nxt = less_r + CNT_W'(1);
      end
      if (tok_r && (circ_r <= own_r)) begin
        leq_nxt = leq_r + CNT_W'(1);
      end
      circ_nxt = circ_in;
      tok_nxt  = tok_in;
    end else if (ctl.select) begin
      circ_nxt = hit ? own_r : circ_in;
    end
  end

  always_ff @(posedge clk) begin
    own_r  <= own_nxt;
    circ_r <= circ_nxt;
    tok_r  <= tok_nxt;
    less_r <= less_nxt;
    leq_r  <= leq_nxt;
  end

  assign own_out  = own_r;
  assign circ_out = circ_r;
  assign tok_out  = tok_r;

endmodule

// ----- rtl/core/msd_ratio.sv -----
// ----------------------------------------------------------------------------
// msd_ratio
// Ratio test of a judged step against the median, using one shared 16 by 24
// bit multiplier in two passes, low half of the median then high half.
// ----------------------------------------------------------------------------
module msd_ratio
  import msd_pkg::*;
(
  input  logic             clk,
  input  msd_mul_t         ctl,
  input  logic [THR_W-1:0] threshold,
  input  logic [MED_W-1:0] median,
  input  logic [MED_W-1:0] step,
  output logic             slow
);

  localparam int PROD_W = THR_W + LO_W;
  localparam int HI_W   = MED_W - LO_W;

  logic [LO_W-1:0]   mul_op;
  logic [PROD_W-1:0] prod_w;
  logic [PROD_W-1:0] prod_lo_r, prod_lo_nxt;
  logic [PROD_W-1:0] prod_hi_r, prod_hi_nxt;
  logic [63:0]       lhs;
  logic [63:0]       rhs;

  assign mul_op = ctl.hi ? {{(LO_W-HI_W){1'b0}}, median[MED_W-1:LO_W]} : median[LO_W-1:0];
  assign prod_w = {{LO_W{1'b0}}, threshold} * {{THR_W{1'b0}}, mul_op};

  always_comb begin
    prod_lo_nxt = ctl.lo ? prod_w : prod_lo_r;
    prod_hi_nxt = ctl.hi ? prod_w : prod_hi_r;
  end

  always_ff @(posedge clk) begin
    prod_lo_r <= prod_lo_nxt;
    prod_hi_r <= prod_hi_nxt;
  end

  assign lhs  = {1'b0, step, 16'b0};
  assign rhs  = {prod_hi_r, {LO_W{1'b0}}} + {{LO_W{1'b0}}, prod_lo_r};
  assign slow = lhs < rhs;

endmodule

// ----- rtl/core/median_ratio_stall_detector.sv -----
// ----------------------------------------------------------------------------
// median_ratio_stall_detector
// Running median of recent positive steps with a ratio threshold and a
// latched stall flag after a run of slow judged steps.
// ----------------------------------------------------------------------------
// One item is taken at a time. A note with a positive step shifts it into a
// chain of RING_DEPTH cells, the oldest dropping out, and the median is then
// rebuilt: every stored step circulates once around the chain while each cell
// counts how many steps lie below and at its own value, and the cell holding
// the upper median then passes its value down the chain; such a note goes
// through the load, rank, select and done states before the next beat is taken.
// A judge that needs the ratio test takes two passes through one 16 by 24
// bit multiplier and a wide compare; any other item goes straight to the
// done state. A new input beat is taken while the previous result waits at
// the output.
module median_ratio_stall_detector
  import msd_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int MIN_SAMPLES = MIN_SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic signed [STEP_W-1:0] in_step_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_verdict,
  output logic              out_stalled,
  output logic [MED_W-1:0]  out_reference_median,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);
  localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(RING_DEPTH - 1);
  localparam logic [CONF_W-1:0] RUN_MAX = '1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOAD   = 8'b0000_0010,
    S_RANK   = 8'b0000_0100,
    S_SELECT = 8'b0000_1000,
    S_MUL_LO = 8'b0001_0000,
    S_MUL_HI = 8'b0010_0000,
    S_DECIDE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  stp_r, stp_nxt;
  logic [CONF_W-1:0] run_r, run_nxt;
  logic              latched_r, latched_nxt;
  logic [MED_W-1:0]  median_r, median_nxt;
  logic              upd_r, upd_nxt;
  verdict_t          vrd_r, vrd_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [CONF_W-1:0] conf_r, conf_nxt;
  logic              out_valid_r, out_valid_nxt;
  verdict_t          out_verdict_r, out_verdict_nxt;
  logic              out_stalled_r, out_stalled_nxt;
  logic [MED_W-1:0]  out_med_r, out_med_nxt;

  msd_ctl_t          ctl;
  msd_mul_t          mctl;
  logic              in_acc;
  logic              cfg_wr;
  logic              positive;
  logic              slow;
  logic [CNT_W-1:0]  k;
  logic [MED_W-1:0]  med_value;
  logic [CONF_W-1:0] run_inc;

  logic [MED_W-1:0]  own_w  [RING_DEPTH];
  logic [MED_W-1:0]  circ_w [RING_DEPTH];
  logic              tok_w  [RING_DEPTH];

  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign in_stall = state_r != S_IDLE;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign positive = !in_step_value[STEP_W-1] && (in_step_value != '0);
  assign k        = cnt_r >> 1;
  assign run_inc  = (run_r == RUN_MAX) ? run_r : run_r + CONF_W'(1);

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = {{(DATA_W-THR_W){1'b0}}, thr_r};
      REG_CONFIRM:   prdata = {{(DATA_W-CONF_W){1'b0}}, conf_r};
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    thr_nxt  = thr_r;
    conf_nxt = conf_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_THRESHOLD: thr_nxt  = pwdata[THR_W-1:0];
        REG_CONFIRM:   conf_nxt = pwdata[CONF_W-1:0];
        default:       thr_nxt  = thr_r;
      endcase
    end
  end

  genvar gi;
  for (gi = 0; gi < RING_DEPTH; gi++) begin : g_cell
    logic [MED_W-1:0] own_in;
    logic [MED_W-1:0] circ_in;
    logic             tok_in;
    logic             valid;

    if (gi == 0) begin : g_head
      assign own_in  = in_step_value[MED_W-1:0];
      assign circ_in = ctl.select ? '0 : circ_w[RING_DEPTH-1];
      assign tok_in  = tok_w[RING_DEPTH-1];
    end else begin : g_body
      assign own_in  = own_w[gi-1];
      assign circ_in = circ_w[gi-1];
      assign tok_in  = tok_w[gi-1];
    end

    assign valid = CNT_W'(gi) < cnt_r;

    msd_cell #(
      .CNT_W(CNT_W)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .valid   (valid),
      .k       (k),
      .own_in  (own_in),
      .own_out (own_w[gi]),
      .circ_in (circ_in),
      .tok_in  (tok_in),
      .circ_out(circ_w[gi]),
      .tok_out (tok_w[gi])
    );
  end

  msd_ratio u_ratio (
    .clk      (clk),
    .ctl      (mctl),
    .threshold(thr_r),
    .median   (median_r),
    .step     (step_r[MED_W-1:0]),
    .slow     (slow)
  );

  always_comb begin
    if (!upd_r) begin
      med_value = median_r;
    end else if (32'(cnt_r) >= MIN_SAMPLES) begin
      med_value = circ_w[RING_DEPTH-1];
    end else begin
      med_value = '0;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    stp_nxt         = stp_r;
    run_nxt         = run_r;
    latched_nxt     = latched_r;
    median_nxt      = median_r;
    upd_nxt         = upd_r;
    vrd_nxt         = vrd_r;
    step_nxt        = step_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_verdict_nxt = out_verdict_r;
    out_stalled_nxt = out_stalled_r;
    out_med_nxt     = out_med_r;
    ctl             = '0;
    mctl            = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          step_nxt  = in_step_value;
          upd_nxt   = 1'b0;
          vrd_nxt   = VERDICT_NONE;
          state_nxt = S_DONE;
          if (in_operation == OP_NOTE) begin
            if (positive) begin
              ctl.shift = 1'b1;
              cnt_nxt   = (cnt_r == DEPTH_C) ? cnt_r : cnt_r + CNT_W'(1);
              upd_nxt   = 1'b1;
              state_nxt = S_LOAD;
            end
          end else if (latched_r) begin
            vrd_nxt = VERDICT_LATCHED;
          end else if ((median_r != '0) && !in_step_value[STEP_W-1]) begin
            state_nxt = S_MUL_LO;
          end
        end
      end
      S_LOAD: begin
        ctl.load  = 1'b1;
        stp_nxt   = '0;
        state_nxt = S_RANK;
      end
      S_RANK: begin
        ctl.rank = 1'b1;
        if (stp_r == LAST_C) begin
          stp_nxt   = '0;
          state_nxt = S_SELECT;
        end else begin
          stp_nxt = stp_r + CNT_W'(1);
        end
      end
      S_SELECT: begin
        ctl.select = 1'b1;
        if (stp_r == LAST_C) begin
          stp_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          stp_nxt = stp_r + CNT_W'(1);
        end
      end
      S_MUL_LO: begin
        mctl.lo   = 1'b1;
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        mctl.hi   = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (slow) begin
          run_nxt = run_inc;
          if (run_inc >= conf_r) begin
            latched_nxt = 1'b1;
            vrd_nxt     = VERDICT_CONFIRMED;
          end else begin
            vrd_nxt = VERDICT_PROVISIONAL;
          end
        end else begin
          run_nxt = '0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = vrd_r;
          out_stalled_nxt = latched_r;
          out_med_nxt     = med_value;
          median_nxt      = med_value;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      stp_r       <= '0;
      run_r       <= '0;
      latched_r   <= 1'b0;
      median_r    <= '0;
      upd_r       <= 1'b0;
      vrd_r       <= VERDICT_NONE;
      thr_r       <= THR_RESET;
      conf_r      <= CONF_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      stp_r       <= stp_nxt;
      run_r       <= run_nxt;
      latched_r   <= latched_nxt;
      median_r    <= median_nxt;
      upd_r       <= upd_nxt;
      vrd_r       <= vrd_nxt;
      thr_r       <= thr_nxt;
      conf_r      <= conf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r        <= step_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_stalled_r <= out_stalled_nxt;
    out_med_r     <= out_med_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_verdict          = out_verdict_r;
  assign out_stalled          = out_stalled_r;
  assign out_reference_median = out_med_r;

endmodule

// ----- rtl/core/msd_checker.sv -----
// ----------------------------------------------------------------------------
// msd_checker
// Port-level checks of the median ratio stall detector, bound to the top
// level.
// ----------------------------------------------------------------------------
module msd_checker
  import msd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_verdict,
  input logic              out_stalled,
  input logic [MED_W-1:0]  out_reference_median
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending_r, pending_nxt;
  logic       seen_r, seen_nxt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    pending_nxt = pending_r + 2'(in_acc) - 2'(out_acc);
    seen_nxt    = seen_r || (out_acc && out_stalled);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      seen_r    <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      seen_r    <= seen_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_verdict) &&
      $stable(out_stalled) && $stable(out_reference_median))
    else $error("Stalled output beat changed.");

  a_no_extra_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("Output beat without an accepted input beat.");

  a_latch_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_r |-> out_stalled)
    else $error("Stall flag dropped after it was reported.");

  a_verdict_latched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict == VERDICT_CONFIRMED || out_verdict == VERDICT_LATCHED)
      |-> out_stalled)
    else $error("Stall verdict without the stall flag.");

  a_verdict_provisional: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict == VERDICT_PROVISIONAL) |-> !out_stalled && !seen_r)
    else $error("Provisional verdict while the stall flag is set.");

endmodule

bind median_ratio_stall_detector msd_checker u_msd_checker (.*);

// ----- dv/stall_detector_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stall_detector_checker
// Watches the step, result and register ports of the median ratio stall
// detector. It keeps its own copy of the step ring, the slow run and the
// latch, and works out each expected result beat when a step beat is taken.
// Each result beat is then compared field by field with the oldest
// expectation.
// ----------------------------------------------------------------------------
module stall_detector_checker
  import msd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_operation,
  input  logic [STEP_W-1:0] in_step_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_verdict,
  input  logic              out_stalled,
  input  logic [MED_W-1:0]  out_reference_median,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fail_count,
  output int                pending,
  output int                checked
);

  typedef struct packed {
    verdict_t          verdict;
    logic              stalled;
    logic [MED_W-1:0]  median;
  } detector_result_t;

  detector_result_t  verdict_queue [$];
  detector_result_t  want;
  logic [STEP_W-1:0] step_ring [RING_DEPTH_DEF];
  int                write_slot;
  int                stored_count;
  int                slow_run;
  logic              latched;
  logic [THR_W-1:0]  thr_reg;
  logic [CONF_W-1:0] conf_reg;

  task automatic report(input string what, input longint unsigned exp_val,
                        input longint unsigned got_val);
    $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, exp_val, got_val,
             $realtime);
    fail_count++;
  endtask

  // Upper median of the stored steps, zero while too few are held.
  function automatic logic [MED_W-1:0] ring_median();
    logic [STEP_W-1:0] sorted_steps [RING_DEPTH_DEF];
    logic [STEP_W-1:0] hold;
    int                j;
    if (stored_count < MIN_SAMPLES_DEF) return '0;
    for (int i = 0; i < stored_count; i++) begin
      hold = step_ring[i];
      j = i;
      while (j > 0 && sorted_steps[j-1] > hold) begin
        sorted_steps[j] = sorted_steps[j-1];
        j--;
      end
      sorted_steps[j] = hold;
    end
    return sorted_steps[stored_count/2][MED_W-1:0];
  endfunction

  function automatic detector_result_t predict_detector(input logic op,
                                                        input logic [STEP_W-1:0] step);
    detector_result_t res;
    logic [63:0]      scaled_step;
    logic [63:0]      limit;
    res.verdict = VERDICT_NONE;
    if (op == OP_NOTE) begin
      if (!step[STEP_W-1] && step != '0) begin
        step_ring[write_slot] = step;
        write_slot = (write_slot + 1) % RING_DEPTH_DEF;
        if (stored_count < RING_DEPTH_DEF) stored_count++;
      end
      res.median = ring_median();
    end else begin
      res.median = ring_median();
      if (latched) begin
        res.verdict = VERDICT_LATCHED;
      end else if (res.median != '0 && !step[STEP_W-1]) begin
        scaled_step = {1'b0, step[STEP_W-2:0], 16'h0};
        limit = 64'(thr_reg) * 64'(res.median);
        if (scaled_step < limit) begin
          if (slow_run < 15) slow_run++;
          if (slow_run >= conf_reg) begin
            latched = 1'b1;
            res.verdict = VERDICT_CONFIRMED;
          end else begin
            res.verdict = VERDICT_PROVISIONAL;
          end
        end else begin
          slow_run = 0;
        end
      end
    end
    res.stalled = latched;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      verdict_queue.delete();
      for (int i = 0; i < RING_DEPTH_DEF; i++) step_ring[i] = '0;
      write_slot = 0;
      stored_count = 0;
      slow_run = 0;
      latched = 1'b0;
      thr_reg = THR_RESET;
      conf_reg = CONF_RESET;
      fail_count = 0;
      checked = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_THRESHOLD: thr_reg = pwdata[THR_W-1:0];
          REG_CONFIRM:   conf_reg = pwdata[CONF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        verdict_queue.push_back(predict_detector(in_operation, in_step_value));
      end
      if (out_valid && !out_stall) begin
        if (verdict_queue.size() == 0) begin
          report("result beat with nothing expected", 0, out_verdict);
        end else begin
          want = verdict_queue.pop_front();
          checked++;
          if (out_verdict !== want.verdict) report("verdict", want.verdict, out_verdict);
          if (out_stalled !== want.stalled) report("stalled", want.stalled, out_stalled);
          if (out_reference_median !== want.median) begin
            report("reference_median", want.median, out_reference_median);
          end
        end
      end
      pending = verdict_queue.size();
    end
  end

endmodule

// ----- dv/tb_median_ratio_stall_detector.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_median_ratio_stall_detector
// Drives note and judge beats into the median ratio stall detector through
// several register settings, with bursty input, a stalling receiver and one
// long output hold. A directed opening covers the field extremes and the
// special steps; the random phases keep the stall latch clear until the last
// phase, where it is allowed to fire.
// ----------------------------------------------------------------------------
module tb_median_ratio_stall_detector;
  import msd_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_operation;
  logic [STEP_W-1:0] in_step_value;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_verdict;
  logic              out_stalled;
  logic [MED_W-1:0]  out_reference_median;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  int                checked;

  // Conservative view of the detector used to keep the latch clear.
  int                stored_n;
  int                slow_guess;
  logic [MED_W-1:0]  max_noted;
  logic [THR_W-1:0]  thr_now;
  logic [CONF_W-1:0] conf_now;
  bit                allow_latch;
  int                n_notes;
  int                n_judges;
  int                n_settings;

  always #5 clk = ~clk;

  median_ratio_stall_detector dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_step_value        (in_step_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_verdict          (out_verdict),
    .out_stalled          (out_stalled),
    .out_reference_median (out_reference_median),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  stall_detector_checker verdict_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_step_value        (in_step_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_verdict          (out_verdict),
    .out_stalled          (out_stalled),
    .out_reference_median (out_reference_median),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .pready               (pready),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .fail_count           (fail_count),
    .pending              (pending),
    .checked              (checked)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [STEP_W-1:0] scaled_step(input int e);
    logic [63:0] one_e;
    one_e = 64'd1 << e;
    return STEP_W'(one_e | (rand64() & (one_e - 64'd1)));
  endfunction

  // At least the largest step ever noted, so never slow once an opinion exists.
  function automatic logic [STEP_W-1:0] sure_fast_step();
    logic [63:0] lo;
    lo = 64'(max_noted);
    return STEP_W'(lo + rand64() % ((64'd1 << MED_W) - lo));
  endfunction

  function automatic logic [STEP_W-1:0] pick_step(input logic op, input int e);
    int          r;
    logic [63:0] near;
    logic [63:0] rnd;
    r = $urandom_range(0, 99);
    rnd = rand64();
    if (op == OP_NOTE) begin
      if (r < 70) return scaled_step(e);
      if (r < 80) return {1'b1, rnd[MED_W-1:0]};
      if (r < 85) return '0;
      return {1'b0, rnd[MED_W-1:0]};
    end
    if (!allow_latch && stored_n >= MIN_SAMPLES_DEF && slow_guess + 1 >= conf_now) begin
      return sure_fast_step();
    end
    if (r < 30) return STEP_W'(rand64() % (64'd1 << (e - 16)));
    if (r < 50) begin
      near = (64'(scaled_step(e)) * 64'(thr_now)) >> 16;
      return STEP_W'(near + 64'($urandom_range(0, 4)) - 64'd2);
    end
    if (r < 65) return sure_fast_step();
    if (r < 75) return {1'b1, rnd[MED_W-1:0]};
    if (r < 80) return '0;
    return rnd[STEP_W-1:0];
  endfunction

  task automatic track_item(input logic op, input logic [STEP_W-1:0] step);
    if (op == OP_NOTE) begin
      n_notes++;
      if (!step[STEP_W-1] && step != '0) begin
        if (stored_n < RING_DEPTH_DEF) stored_n++;
        if (step[MED_W-1:0] > max_noted) max_noted = step[MED_W-1:0];
      end
    end else begin
      n_judges++;
      if (stored_n >= MIN_SAMPLES_DEF && !step[STEP_W-1]) begin
        if (step[MED_W-1:0] >= max_noted) slow_guess = 0;
        else if (slow_guess < 15) slow_guess++;
      end
    end
  endtask

  task automatic send(input logic op, input logic [STEP_W-1:0] step);
    bit go;
    in_valid <= 1'b1;
    in_operation <= op;
    in_step_value <= step;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
    track_item(op, step);
  endtask

  task automatic cfg_write(input logic idx, input logic [DATA_W-1:0] value);
    bit rdy;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [THR_W-1:0] thr, input logic [CONF_W-1:0] conf,
                           input int n_items, input bit latch_ok);
    int   gap;
    int   burst_left;
    int   e;
    logic op;
    drain();
    cfg_write(REG_THRESHOLD, {16'($urandom_range(0, 65535)), thr});
    cfg_write(REG_CONFIRM, {16'($urandom_range(0, 65535)), 12'h0, conf});
    thr_now = thr;
    conf_now = conf;
    allow_latch = latch_ok;
    n_settings++;
    e = $urandom_range(20, 44);
    burst_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 16);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      op = ($urandom_range(0, 1) == 0) ? OP_NOTE : OP_JUDGE;
      send(op, pick_step(op, e));
    end
  endtask

  initial begin
    int mode_left;
    int hold_left;
    int cyc;
    bit held_once;
    bit stall_now;
    out_stall <= 1'b0;
    mode_left = 0;
    hold_left = 0;
    cyc = 0;
    held_once = 0;
    stall_now = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!held_once && cyc == 3000) begin
        hold_left = 400;
        held_once = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          if ($urandom_range(0, 9) < 2) begin
            stall_now = 0;
            mode_left = $urandom_range(20, 60);
          end else begin
            stall_now = !stall_now;
            mode_left = stall_now ? $urandom_range(1, 4) : $urandom_range(1, 6);
          end
        end
        mode_left--;
        out_stall <= stall_now;
      end
    end
  end

  initial begin
    #5000000;
    $display("Run did not finish in time.");
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int waited;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_NOTE;
    in_step_value <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    stored_n = 0;
    slow_guess = 0;
    max_noted = '0;
    thr_now = THR_RESET;
    conf_now = CONF_RESET;
    allow_latch = 0;
    n_notes = 0;
    n_judges = 0;
    n_settings = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening with reset register values: empty ring, ignored notes, the
    // extremes of the step, and judges on both sides of the threshold.
    send(OP_JUDGE, '0);
    send(OP_NOTE, '0);
    send(OP_NOTE, 48'hFFFF_FFFF_FFFF);
    send(OP_NOTE, 48'h8000_0000_0000);
    send(OP_NOTE, 48'h7FFF_FFFF_FFFF);
    send(OP_NOTE, 48'd1);
    send(OP_JUDGE, 48'd1);
    send(OP_NOTE, 48'd1 << 40);
    send(OP_NOTE, 48'd1 << 39);
    send(OP_JUDGE, '0);
    send(OP_NOTE, 48'd1 << 41);
    send(OP_JUDGE, '0);
    send(OP_JUDGE, 48'h8000_0000_0000);
    send(OP_JUDGE, 48'd1);
    send(OP_JUDGE, 48'h7FFF_FFFF_FFFF);
    send(OP_JUDGE, 48'd1311 << 24);
    send(OP_JUDGE, (48'd1311 << 24) - 48'd1);
    send(OP_JUDGE, 48'd1 << 46);
    send(OP_JUDGE, 48'h7FFF_FFFF_FFFF);

    run_phase(16'd1311, 4'd15, 150, 0);
    run_phase(16'd65535, 4'd15, 150, 0);
    run_phase(16'd1, 4'd15, 110, 0);
    run_phase(THR_W'($urandom_range(2, 65534)), CONF_W'($urandom_range(2, 14)), 150, 0);
    run_phase(16'd0, 4'd7, 100, 0);
    run_phase(THR_W'($urandom_range(1, 65535)), 4'd1, 60, 0);
    run_phase(THR_W'($urandom_range(20000, 65535)), 4'd0, 100, 1);

    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (pending != 0) $display("%0d expected result beats never arrived.", pending);

    $display("Sent %0d notes and %0d judges under %0d register settings, with one long",
             n_notes, n_judges, n_settings);
    $display("output hold; %0d result beats checked, %0d mismatches.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- median_ratio_stall_detector.f -----
rtl/core/msd_pkg.sv
rtl/core/msd_cell.sv
rtl/core/msd_ratio.sv
rtl/core/median_ratio_stall_detector.sv
rtl/core/msd_checker.sv
dv/stall_detector_checker.sv
dv/tb_median_ratio_stall_detector.sv
